### rtl/dnar_pkg.sv
package dnar_pkg;

   typedef logic [2:0] base_type;

   localparam base_type BASE_A = 3'd0;
   localparam base_type BASE_C = 3'd1;
   localparam base_type BASE_G = 3'd2;
   localparam base_type BASE_T = 3'd3;
   localparam base_type BASE_N = 3'd4;

   localparam logic [1:0] FUNC_SHIFT = 2'd0;
   localparam logic [1:0] FUNC_NOISE = 2'd1;
   localparam logic [1:0] FUNC_EMIT  = 2'd2;

   localparam logic [1:0] REG_READ_LENGTH = 2'd0;

   localparam logic [8:0] NOISE_POS_MAX = 9'd511;
   localparam logic [6:0] LEN_RESET     = 7'd64;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_NOISE_RD = 4'b0010,
      ST_NOISE_WR = 4'b0100,
      ST_EMIT     = 4'b1000
   } state_type;

   typedef struct packed {
      base_type base;
      logic     last;
   } rsp_entry_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] count;
   } fifo_status_type;

   // replacement base chosen by reference base and noise code
   function automatic base_type noise_sub(input base_type ref_b, input logic [1:0] code);
      base_type r;
      r = BASE_N;
      unique case (ref_b)
         BASE_A: begin
            unique case (code)
               2'd0: r = BASE_C;
               2'd1: r = BASE_G;
               2'd2: r = BASE_T;
               default: r = BASE_N;
            endcase
         end
         BASE_C: begin
            unique case (code)
               2'd0: r = BASE_A;
               2'd1: r = BASE_G;
               2'd2: r = BASE_T;
               default: r = BASE_N;
            endcase
         end
         BASE_G: begin
            unique case (code)
               2'd0: r = BASE_T;
               2'd1: r = BASE_A;
               2'd2: r = BASE_C;
               default: r = BASE_N;
            endcase
         end
         BASE_T: begin
            unique case (code)
               2'd0: r = BASE_G;
               2'd1: r = BASE_C;
               2'd2: r = BASE_A;
               default: r = BASE_N;
            endcase
         end
         default: begin
            unique case (code)
               2'd0: r = BASE_A;
               2'd1: r = BASE_G;
               2'd2: r = BASE_C;
               default: r = BASE_T;
            endcase
         end
      endcase
      return r;
   endfunction

   // complement, n maps to n
   function automatic base_type complement(input base_type b);
      base_type r;
      r = BASE_N;
      unique case (b)
         BASE_A:  r = BASE_T;
         BASE_C:  r = BASE_G;
         BASE_G:  r = BASE_C;
         BASE_T:  r = BASE_A;
         default: r = BASE_N;
      endcase
      return r;
   endfunction

endpackage

### rtl/dna_read_reconstructor_top.sv
// dna read reconstructor
// input channel (req_*): one item per valid/stall handshake. func 0 shifts a
// base into the reference ring, func 1 records a noise substitution, func 2
// emits the current read, func 3 is ignored.
// result channel (rsp_*): func 2 yields read_length items, one base each, with
// rsp_last_base on the final one and rsp_noise_dropped set for the whole read
// if any noise position of that read fell beyond it.
// configuration: apb-style write of read_length at address 0, idle only; the
// block itself does not enforce this, the user is bound to keep it.
// timing: shift items and noise items beyond the read leave req_stall low; a
// noise item inside the read steps through accept, window ram read and
// substitution ram write. for emit, one window/substitution ram read issues
// per cycle while the queue credit allows; registered read data lands in a
// 2-entry output queue, whose bases are offered one per cycle unless stalled.
// req_stall is high from the accept of an emit item or an in-read noise item
// until its work is done; for emit, until the last base leaves the queue.
// when the receiver stalls, reads stop once the queue and the read in flight
// would fill it, and resume as items are taken; nothing is lost.
// reset: window reads as all A through per-slot valid bits, substitution mask,
// noise position and drop flag clear, read_length returns to 64. no clearing
// pass is needed, the block accepts items in the first cycle after reset.
module dna_read_reconstructor_top
   import dnar_pkg::*;
#(
   parameter int MAX_READ_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_base_in,
   input  logic [7:0]  req_pos_delta,
   input  logic [1:0]  req_noise_code,
   input  logic        req_reverse,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_base_out,
   output logic        rsp_last_base,
   output logic        rsp_noise_dropped,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
   localparam logic [6:0] MAX_W7 = 7'(MAX_READ_LEN);
   localparam logic [7:0] MAX_W8 = 8'(MAX_READ_LEN);
   localparam logic [AW-1:0] HEAD_LAST = AW'(MAX_READ_LEN - 1);

   // control and config state
   state_type         state_ff, state_in;
   logic [6:0]        rl_ff, rl_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [8:0]        pos_ff, pos_in;
   logic              dropped_ff, dropped_in;
   logic [1:0]        code_ff, code_in;
   logic              rev_ff, rev_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              inflight_ff, inflight_in;
   logic [MAX_READ_LEN-1:0] mask_ff, mask_in;
   logic [MAX_READ_LEN-1:0] refv_ff, refv_in;
   // side data captured with each ram read
   logic              mask_q_ff, mask_q_in;
   logic              refv_q_ff, refv_q_in;
   logic              last_q_ff, last_q_in;

   logic [6:0]        len;
   logic              req_accept;
   logic              rsp_pop;
   logic [9:0]        pos_sum;
   logic [8:0]        pos_new;
   logic [6:0]        rd_idx;
   logic [6:0]        emit_idx;
   logic [7:0]        slot_sum;
   logic [7:0]        slot8;
   logic [AW-1:0]     ref_raddr;
   logic [AW-1:0]     idx_a;
   logic              issue;
   logic [2:0]        occupancy;

   // ram ports
   logic              ref_we;
   base_type          ref_rdata;
   logic              sub_we;
   base_type          sub_wdata;
   base_type          sub_rdata;

   // queue
   logic              push;
   rsp_entry_type     push_data;
   rsp_entry_type     q_head;
   fifo_status_type   q_status;
   base_type          picked;

   // effective length, clamped to 1..MAX_READ_LEN
   always_comb begin
      if (rl_ff == 7'd0) begin
         len = 7'd1;
      end else if (rl_ff > MAX_W7) begin
         len = MAX_W7;
      end else begin
         len = rl_ff;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = q_status.valid;
   assign rsp_pop    = q_status.valid && !rsp_stall;

   // running noise position, saturating
   assign pos_sum = {1'b0, pos_ff} + {2'b0, req_pos_delta};
   assign pos_new = (pos_sum > {1'b0, NOISE_POS_MAX}) ? NOISE_POS_MAX : pos_sum[8:0];

   // read index: noise position, or emit order (reverse walks from the end)
   assign emit_idx = rev_ff ? (len - 7'd1 - cnt_ff) : cnt_ff;
   assign rd_idx   = (state_ff == ST_NOISE_RD) ? pos_ff[6:0] : emit_idx;
   assign idx_a    = rd_idx[AW-1:0];

   // ring slot of read index: head - len + idx, modulo depth (one correction)
   assign slot_sum  = 8'(head_ff) + MAX_W8 - {1'b0, len} + {1'b0, rd_idx};
   assign slot8     = (slot_sum >= MAX_W8) ? (slot_sum - MAX_W8) : slot_sum;
   assign ref_raddr = slot8[AW-1:0];

   // emit issue credit: queue entries plus the read in flight stay within two
   assign occupancy = {1'b0, q_status.count} + {2'b0, inflight_ff} - {2'b0, rsp_pop};
   assign issue     = (state_ff == ST_EMIT) && (cnt_ff < len) && (occupancy < 3'd2);

   // window ram writes on shift items, bases above n stored as n
   assign ref_we = req_accept && (req_func == FUNC_SHIFT);

   // substitution taken from the reference base as read at the noise item
   assign sub_we    = (state_ff == ST_NOISE_WR);
   assign sub_wdata = noise_sub(refv_q_ff ? ref_rdata : BASE_A, code_ff);

   // emit data stage
   always_comb begin
      picked = mask_q_ff ? sub_rdata : (refv_q_ff ? ref_rdata : BASE_A);
      push_data.base = rev_ff ? complement(picked) : picked;
      push_data.last = last_q_ff;
   end
   assign push = inflight_ff;

   always_comb begin
      state_in    = state_ff;
      rl_in       = rl_ff;
      head_in     = head_ff;
      pos_in      = pos_ff;
      dropped_in  = dropped_ff;
      code_in     = code_ff;
      rev_in      = rev_ff;
      cnt_in      = cnt_ff;
      inflight_in = issue;
      mask_in     = mask_ff;
      refv_in     = refv_ff;
      mask_q_in   = mask_ff[idx_a];
      refv_q_in   = refv_ff[ref_raddr];
      last_q_in   = (cnt_ff == len - 7'd1);

      if (psel && penable && pwrite && pready && (paddr == REG_READ_LENGTH)) begin
         rl_in = pwdata[6:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  FUNC_SHIFT: begin
                     refv_in[head_ff] = 1'b1;
                     head_in = (head_ff == HEAD_LAST) ? '0 : head_ff + AW'(1);
                  end
                  FUNC_NOISE: begin
                     pos_in  = pos_new;
                     code_in = req_noise_code;
                     if (pos_new < {2'b0, len}) begin
                        state_in = ST_NOISE_RD;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  FUNC_EMIT: begin
                     rev_in   = req_reverse;
                     cnt_in   = 7'd0;
                     state_in = ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_NOISE_RD: begin
            state_in = ST_NOISE_WR;
         end
         ST_NOISE_WR: begin
            mask_in[pos_ff[AW-1:0]] = 1'b1;
            state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (issue) begin
               cnt_in = cnt_ff + 7'd1;
            end
            // read is done once its last base is taken
            if (rsp_pop && q_head.last) begin
               mask_in    = '0;
               pos_in     = 9'd0;
               dropped_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rl_ff       <= LEN_RESET;
         head_ff     <= '0;
         pos_ff      <= 9'd0;
         dropped_ff  <= 1'b0;
         cnt_ff      <= 7'd0;
         inflight_ff <= 1'b0;
         mask_ff     <= '0;
         refv_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         rl_ff       <= rl_in;
         head_ff     <= head_in;
         pos_ff      <= pos_in;
         dropped_ff  <= dropped_in;
         cnt_ff      <= cnt_in;
         inflight_ff <= inflight_in;
         mask_ff     <= mask_in;
         refv_ff     <= refv_in;
      end
      code_ff   <= code_in;
      rev_ff    <= rev_in;
      mask_q_ff <= mask_q_in;
      refv_q_ff <= refv_q_in;
      last_q_ff <= last_q_in;
   end

   // reference window ring
   dnar_ram #(
      .WIDTH (3),
      .DEPTH (MAX_READ_LEN)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (head_ff),
      .wr_data ((req_base_in > BASE_N) ? BASE_N : req_base_in),
      .rd_addr (ref_raddr),
      .rd_data (ref_rdata)
   );

   // substituted bases by read position
   dnar_ram #(
      .WIDTH (3),
      .DEPTH (MAX_READ_LEN)
   ) u_sub_ram (
      .clock   (clock),
      .wr_en   (sub_we),
      .wr_addr (pos_ff[AW-1:0]),
      .wr_data (sub_wdata),
      .rd_addr (idx_a),
      .rd_data (sub_rdata)
   );

   dnar_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_pop),
      .head      (q_head),
      .status    (q_status)
   );

   assign rsp_base_out      = q_head.base;
   assign rsp_last_base     = q_head.last;
   assign rsp_noise_dropped = dropped_ff;

   assign pready = 1'b1;
   assign prdata = (paddr == REG_READ_LENGTH) ? {25'd0, rl_ff} : 32'd0;

   // no results left over while the block takes items
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !q_status.valid && !inflight_ff)
      else $error("results pending while idle");

   // queue plus read in flight never exceeds queue depth
   a_credit: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, q_status.count} + {2'b0, inflight_ff}) <= 3'd2)
      else $error("output queue overrun");

   // emit counter stays within the read
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff <= len))
      else $error("emit counter past read length");

   // a noise read is always followed by its write
   a_noise_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NOISE_RD) |=> (state_ff == ST_NOISE_WR))
      else $error("noise write skipped");

endmodule

### rtl/dnar_ram.sv
module dnar_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/dnar_out_fifo.sv
module dnar_out_fifo
   import dnar_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_entry_type   push_data,
   input  logic            pop,
   output rsp_entry_type   head,
   output fifo_status_type status
);

   rsp_entry_type ent0_ff, ent0_in;
   rsp_entry_type ent1_ff, ent1_in;
   logic [1:0]    count_ff, count_in;
   logic [1:0]    wpos;

   always_comb begin
      ent0_in  = ent0_ff;
      ent1_in  = ent1_ff;
      wpos     = count_ff - {1'b0, pop};
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         ent0_in = ent1_ff;
      end
      if (push) begin
         if (wpos == 2'd0) begin
            ent0_in = push_data;
         end else begin
            ent1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

   assign head   = ent0_ff;
   assign status = {(count_ff != 2'd0), count_ff};

endmodule
